// ===== hw/rtl/acms_pkg.sv =====
package acms_pkg;

	// Default sizes of the automaton stores.
	localparam int DEF_NUM_STATES    = 1024;
	localparam int DEF_ALPHABET_SIZE = 256;
	localparam int DEF_NUM_OUTPUTS   = 1024;
	localparam int DEF_MAX_RESULTS   = 64;

	// Fixed field widths of the channels.
	localparam int POS_W     = 48;
	localparam int PAT_W     = 16;
	localparam int IDX_W     = 10;
	localparam int OP_W      = 3;
	localparam int SYM_W     = 8;
	localparam int CFG_IDX_W = 2;
	// Widest internal store index that any parameter value can ask for.
	localparam int ADDR_MAX_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_SCAN   = 3'd0,
		OP_TRANS  = 3'd1,
		OP_HEAD   = 3'd2,
		OP_SUFFIX = 3'd3,
		OP_ENTRY  = 3'd4
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CORE_END   = 2'd2;

	// Table write request, taken straight from an accepted input transaction.
	typedef struct packed {
		logic                valid;
		logic [OP_W-1:0]     opcode;
		logic [SYM_W-1:0]    data_byte;
		logic [IDX_W-1:0]    state_index;
		logic [IDX_W-1:0]    target_state;
		logic                target_valid;
		logic [IDX_W-1:0]    output_index;
		logic                output_valid;
		logic [PAT_W-1:0]    pattern_number;
		logic [IDX_W-1:0]    next_output_index;
		logic                next_output_valid;
	} wr_req_t;

	// Read requests to the stores; each read port holds its data when not enabled.
	typedef struct packed {
		logic                  trans_en;
		logic [ADDR_MAX_W-1:0] trans_state;
		logic [SYM_W-1:0]      trans_sym;
		logic                  node_en;
		logic [ADDR_MAX_W-1:0] node_state;
		logic                  ent_en;
		logic [ADDR_MAX_W-1:0] ent_idx;
	} rd_req_t;

	// One result pushed from the sequencer into the output register.
	typedef struct packed {
		logic             push;
		logic [POS_W-1:0] end_position;
		logic [PAT_W-1:0] matched_pattern;
		logic             last_of_byte;
		logic             overflow;
	} push_t;

endpackage

// ===== hw/rtl/acms_item_if.sv =====
interface acms_item_if;
	logic                           valid;
	logic                           ready;
	logic [acms_pkg::OP_W-1:0]      opcode;
	logic [acms_pkg::SYM_W-1:0]     data_byte;
	logic                           restart;
	logic [acms_pkg::IDX_W-1:0]     state_index;
	logic [acms_pkg::IDX_W-1:0]     target_state;
	logic                           target_valid;
	logic [acms_pkg::IDX_W-1:0]     output_index;
	logic                           output_valid;
	logic [acms_pkg::PAT_W-1:0]     pattern_number;
	logic [acms_pkg::IDX_W-1:0]     next_output_index;
	logic                           next_output_valid;

	modport source (
		output valid, opcode, data_byte, restart, state_index, target_state, target_valid,
		output output_index, output_valid, pattern_number, next_output_index,
		output next_output_valid,
		input  ready
	);

	modport sink (
		input  valid, opcode, data_byte, restart, state_index, target_state, target_valid,
		input  output_index, output_valid, pattern_number, next_output_index,
		input  next_output_valid,
		output ready
	);
endinterface

// ===== hw/rtl/acms_result_if.sv =====
interface acms_result_if;
	logic                       valid;
	logic                       ready;
	logic [acms_pkg::POS_W-1:0] end_position;
	logic [acms_pkg::PAT_W-1:0] matched_pattern;
	logic                       last_of_byte;
	logic                       overflow;

	modport source (
		output valid, end_position, matched_pattern, last_of_byte, overflow,
		input  ready
	);

	modport sink (
		input  valid, end_position, matched_pattern, last_of_byte, overflow,
		output ready
	);
endinterface

// ===== hw/rtl/acms_cfg_if.sv =====
interface acms_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [acms_pkg::CFG_IDX_W-1:0] index;
	logic [acms_pkg::POS_W-1:0]     data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== hw/rtl/acms_tables.sv =====
module acms_tables #(
	parameter int NUM_STATES    = acms_pkg::DEF_NUM_STATES,
	parameter int ALPHABET_SIZE = acms_pkg::DEF_ALPHABET_SIZE,
	parameter int NUM_OUTPUTS   = acms_pkg::DEF_NUM_OUTPUTS,
	localparam int SW           = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
	localparam int OW           = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
	input  logic                 clk,
	input  acms_pkg::wr_req_t    wr,
	input  acms_pkg::rd_req_t    rd,
	output logic [SW-1:0]        trans_state,
	output logic [OW:0]          head_link,
	output logic [SW:0]          sfx_link,
	output logic [acms_pkg::PAT_W-1:0] ent_pattern,
	output logic [OW:0]          ent_next
);

	localparam int AW     = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
	localparam int TDEPTH = NUM_STATES * (2 ** AW);
	localparam int XW     = acms_pkg::ADDR_MAX_W + 1;

	// Transition rows are addressed as {state, symbol}.
	logic [SW-1:0]              trans_mem [TDEPTH];
	logic [OW:0]                head_mem  [NUM_STATES];
	logic [SW:0]                sfx_mem   [NUM_STATES];
	logic [acms_pkg::PAT_W-1:0] pat_mem   [NUM_OUTPUTS];
	logic [OW:0]                nxt_mem   [NUM_OUTPUTS];

	logic [XW-1:0] si_ext, ts_ext, oi_ext, ni_ext;
	logic          si_ok, ts_ok, oi_ok, ni_ok, sym_ok;
	logic          we_trans, we_head, we_sfx, we_ent;
	logic [SW:0]   sfx_wdata;
	logic [OW:0]   head_wdata, nxt_wdata;

	assign si_ext = XW'(wr.state_index);
	assign ts_ext = XW'(wr.target_state);
	assign oi_ext = XW'(wr.output_index);
	assign ni_ext = XW'(wr.next_output_index);
	assign si_ok  = si_ext < XW'(NUM_STATES);
	assign ts_ok  = ts_ext < XW'(NUM_STATES);
	assign oi_ok  = oi_ext < XW'(NUM_OUTPUTS);
	assign ni_ok  = ni_ext < XW'(NUM_OUTPUTS);
	assign sym_ok = {1'b0, wr.data_byte} < 9'(ALPHABET_SIZE);

	assign we_trans = wr.valid && (wr.opcode == acms_pkg::OP_TRANS) && si_ok && sym_ok && ts_ok;
	assign we_head  = wr.valid && (wr.opcode == acms_pkg::OP_HEAD) && si_ok;
	assign we_sfx   = wr.valid && (wr.opcode == acms_pkg::OP_SUFFIX) && si_ok;
	assign we_ent   = wr.valid && (wr.opcode == acms_pkg::OP_ENTRY) && oi_ok;

	// A link whose index falls outside its store is kept as nil.
	assign head_wdata = (wr.output_valid && oi_ok) ? {1'b1, oi_ext[OW-1:0]} : '0;
	assign sfx_wdata  = (wr.target_valid && ts_ok) ? {1'b1, ts_ext[SW-1:0]} : '0;
	assign nxt_wdata  = (wr.next_output_valid && ni_ok) ? {1'b1, ni_ext[OW-1:0]} : '0;

	always_ff @(posedge clk) begin
		if (we_trans) begin
			trans_mem[{si_ext[SW-1:0], wr.data_byte[AW-1:0]}] <= ts_ext[SW-1:0];
		end
		if (we_head) begin
			head_mem[si_ext[SW-1:0]] <= head_wdata;
		end
		if (we_sfx) begin
			sfx_mem[si_ext[SW-1:0]] <= sfx_wdata;
		end
		if (we_ent) begin
			pat_mem[oi_ext[OW-1:0]] <= wr.pattern_number;
			nxt_mem[oi_ext[OW-1:0]] <= nxt_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.trans_en) begin
			trans_state <= trans_mem[{rd.trans_state[SW-1:0], rd.trans_sym[AW-1:0]}];
		end
		if (rd.node_en) begin
			head_link <= head_mem[rd.node_state[SW-1:0]];
			sfx_link  <= sfx_mem[rd.node_state[SW-1:0]];
		end
		if (rd.ent_en) begin
			ent_pattern <= pat_mem[rd.ent_idx[OW-1:0]];
			ent_next    <= nxt_mem[rd.ent_idx[OW-1:0]];
		end
	end

endmodule

// ===== hw/rtl/acms_seq.sv =====
module acms_seq #(
	parameter int NUM_STATES    = acms_pkg::DEF_NUM_STATES,
	parameter int ALPHABET_SIZE = acms_pkg::DEF_ALPHABET_SIZE,
	parameter int NUM_OUTPUTS   = acms_pkg::DEF_NUM_OUTPUTS,
	parameter int MAX_RESULTS   = acms_pkg::DEF_MAX_RESULTS,
	localparam int SW           = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1,
	localparam int OW           = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	acms_item_if.sink                  item,
	input  logic [acms_pkg::POS_W-1:0] base_pos,
	input  logic [acms_pkg::POS_W-1:0] rpt_lo,
	input  logic [acms_pkg::POS_W-1:0] rpt_hi,
	input  logic                       out_free,
	output acms_pkg::wr_req_t          wr,
	output acms_pkg::rd_req_t          rd,
	input  logic [SW-1:0]              trans_state,
	input  logic [OW:0]                head_link,
	input  logic [SW:0]                sfx_link,
	input  logic [acms_pkg::PAT_W-1:0] ent_pattern,
	input  logic [OW:0]                ent_next,
	output acms_pkg::push_t            push
);

	localparam int CW = $clog2(MAX_RESULTS + 1);
	localparam int HW = $clog2(NUM_STATES + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_TRANS = 5'b00010,
		ST_HEAD  = 5'b00100,
		ST_ENTRY = 5'b01000,
		ST_FLUSH = 5'b10000
	} st_t;

	st_t                        st_q, st_d;
	logic [SW-1:0]              cur_q, cur_d;
	logic [acms_pkg::POS_W-1:0] pos_q, pos_d;
	logic [acms_pkg::POS_W-1:0] bpos_q, bpos_d;
	logic                       rep_q, rep_d;
	logic [CW-1:0]              cnt_q, cnt_d;
	logic [HW-1:0]              hops_q, hops_d;
	logic                       cut_q, cut_d;
	logic                       pend_v_q, pend_v_d;
	logic [acms_pkg::PAT_W-1:0] pend_pat_q, pend_pat_d;
	logic                       sfx_v_q, sfx_v_d;
	logic [SW-1:0]              sfx_idx_q, sfx_idx_d;

	logic                       accept, is_scan, byte_ok;
	logic [SW-1:0]              eff_state;
	logic [acms_pkg::POS_W-1:0] eff_pos;
	logic [HW-1:0]              hops_inc;
	logic [CW-1:0]              cnt_inc;

	assign item.ready = (st_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign is_scan    = (item.opcode == acms_pkg::OP_SCAN);
	assign byte_ok    = {1'b0, item.data_byte} < 9'(ALPHABET_SIZE);
	assign eff_state  = item.restart ? '0 : cur_q;
	assign eff_pos    = item.restart ? base_pos : pos_q;
	assign hops_inc   = hops_q + HW'(1);
	assign cnt_inc    = cnt_q + CW'(1);

	always_comb begin
		wr.valid             = accept && !is_scan;
		wr.opcode            = item.opcode;
		wr.data_byte         = item.data_byte;
		wr.state_index       = item.state_index;
		wr.target_state      = item.target_state;
		wr.target_valid      = item.target_valid;
		wr.output_index      = item.output_index;
		wr.output_valid      = item.output_valid;
		wr.pattern_number    = item.pattern_number;
		wr.next_output_index = item.next_output_index;
		wr.next_output_valid = item.next_output_valid;
	end

	always_comb begin
		st_d       = st_q;
		cur_d      = cur_q;
		pos_d      = pos_q;
		bpos_d     = bpos_q;
		rep_d      = rep_q;
		cnt_d      = cnt_q;
		hops_d     = hops_q;
		cut_d      = cut_q;
		pend_v_d   = pend_v_q;
		pend_pat_d = pend_pat_q;
		sfx_v_d    = sfx_v_q;
		sfx_idx_d  = sfx_idx_q;
		rd         = '0;
		push       = '0;

		unique case (st_q)
			ST_IDLE: begin
				if (accept && is_scan) begin
					cur_d    = eff_state;
					pos_d    = eff_pos;
					cnt_d    = '0;
					hops_d   = '0;
					cut_d    = 1'b0;
					pend_v_d = 1'b0;
					if (eff_pos < rpt_hi) begin
						pos_d  = eff_pos + acms_pkg::POS_W'(1);
						bpos_d = eff_pos;
						rep_d  = (eff_pos >= rpt_lo);
						if (byte_ok) begin
							rd.trans_en    = 1'b1;
							rd.trans_state = acms_pkg::ADDR_MAX_W'(eff_state);
							rd.trans_sym   = item.data_byte;
							st_d           = ST_TRANS;
						end else if (eff_pos >= rpt_lo) begin
							rd.node_en    = 1'b1;
							rd.node_state = acms_pkg::ADDR_MAX_W'(eff_state);
							st_d          = ST_HEAD;
						end
					end
				end
			end
			ST_TRANS: begin
				cur_d = trans_state;
				if (rep_q) begin
					rd.node_en    = 1'b1;
					rd.node_state = acms_pkg::ADDR_MAX_W'(trans_state);
					st_d          = ST_HEAD;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_HEAD: begin
				hops_d    = hops_inc;
				sfx_v_d   = sfx_link[SW];
				sfx_idx_d = sfx_link[SW-1:0];
				if (head_link[OW]) begin
					if (cnt_q == CW'(MAX_RESULTS)) begin
						cut_d = 1'b1;
						st_d  = ST_FLUSH;
					end else begin
						rd.ent_en  = 1'b1;
						rd.ent_idx = acms_pkg::ADDR_MAX_W'(head_link[OW-1:0]);
						st_d       = ST_ENTRY;
					end
				end else if (sfx_link[SW] && (hops_inc < HW'(NUM_STATES))) begin
					rd.node_en    = 1'b1;
					rd.node_state = acms_pkg::ADDR_MAX_W'(sfx_link[SW-1:0]);
				end else begin
					st_d = ST_FLUSH;
				end
			end
			ST_ENTRY: begin
				// The previous result goes out once we know it is not the last one.
				if (!pend_v_q || out_free) begin
					if (pend_v_q) begin
						push.push            = 1'b1;
						push.end_position    = bpos_q;
						push.matched_pattern = pend_pat_q;
					end
					pend_v_d   = 1'b1;
					pend_pat_d = ent_pattern;
					cnt_d      = cnt_inc;
					if (ent_next[OW]) begin
						if (cnt_inc == CW'(MAX_RESULTS)) begin
							cut_d = 1'b1;
							st_d  = ST_FLUSH;
						end else begin
							rd.ent_en  = 1'b1;
							rd.ent_idx = acms_pkg::ADDR_MAX_W'(ent_next[OW-1:0]);
						end
					end else if (sfx_v_q && (hops_q < HW'(NUM_STATES))) begin
						rd.node_en    = 1'b1;
						rd.node_state = acms_pkg::ADDR_MAX_W'(sfx_idx_q);
						st_d          = ST_HEAD;
					end else begin
						st_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					st_d = ST_IDLE;
				end else if (out_free) begin
					push.push            = 1'b1;
					push.end_position    = bpos_q;
					push.matched_pattern = pend_pat_q;
					push.last_of_byte    = 1'b1;
					push.overflow        = cut_q;
					pend_v_d             = 1'b0;
					st_d                 = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			cur_q    <= '0;
			pos_q    <= '0;
			rep_q    <= 1'b0;
			cnt_q    <= '0;
			hops_q   <= '0;
			cut_q    <= 1'b0;
			pend_v_q <= 1'b0;
			sfx_v_q  <= 1'b0;
		end else begin
			st_q     <= st_d;
			cur_q    <= cur_d;
			pos_q    <= pos_d;
			rep_q    <= rep_d;
			cnt_q    <= cnt_d;
			hops_q   <= hops_d;
			cut_q    <= cut_d;
			pend_v_q <= pend_v_d;
			sfx_v_q  <= sfx_v_d;
		end
	end

	always_ff @(posedge clk) begin
		bpos_q     <= bpos_d;
		pend_pat_q <= pend_pat_d;
		sfx_idx_q  <= sfx_idx_d;
	end

endmodule

// ===== hw/rtl/aho_corasick_match_scanner.sv =====
// Multi-pattern byte scanner built on a table-driven Aho-Corasick automaton.
// The item channel carries table loads and text bytes. A load is taken while
// the scanner is idle and writes the transition table, an own-output head, a
// suffix link or an output entry. A warm-up or reporting byte steps the state
// through the registered read of the transition memory, and a byte at or past
// the core end leaves the state as it is. A reporting byte then walks the
// suffix chain, visiting each state and each output entry in turn, and then
// releases the final result; a byte outside the alphabet skips the table
// read. The item channel is not ready while a byte is in progress.
// Results leave through an output register on the result channel, one
// transaction per pattern found, the last one of a byte flagged, and the walk
// is cut after MAX_RESULTS results with overflow set on that final result.
// When the receiver stalls, the output register holds its result and the walk
// waits for it; a new item is still taken while the last result waits.
// The cfg channel is always ready and writes the three position registers.
// Reset puts the automaton at the root state with the position at zero; the
// table memories keep whatever they held and must be loaded before use.
module aho_corasick_match_scanner #(
	parameter int NUM_STATES    = acms_pkg::DEF_NUM_STATES,
	parameter int ALPHABET_SIZE = acms_pkg::DEF_ALPHABET_SIZE,
	parameter int NUM_OUTPUTS   = acms_pkg::DEF_NUM_OUTPUTS,
	parameter int MAX_RESULTS   = acms_pkg::DEF_MAX_RESULTS
) (
	input  logic          clk,
	input  logic          arst_n,
	acms_item_if.sink     item,
	acms_result_if.source result,
	acms_cfg_if.sink      cfg
);

	localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int OW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

	// Position registers; the user must write configuration only while the scanner is idle (not enforced here).
	logic [acms_pkg::POS_W-1:0] base_pos_q;
	logic [acms_pkg::POS_W-1:0] rpt_lo_q;
	logic [acms_pkg::POS_W-1:0] rpt_hi_q;

	// Output register between the sequencer and the result channel.
	logic                       res_valid_q;
	logic [acms_pkg::POS_W-1:0] res_pos_q;
	logic [acms_pkg::PAT_W-1:0] res_pat_q;
	logic                       res_last_q;
	logic                       res_ovf_q;
	logic                       out_free;

	acms_pkg::wr_req_t          wr;
	acms_pkg::rd_req_t          rd;
	acms_pkg::push_t            push;
	logic [SW-1:0]              trans_state;
	logic [OW:0]                head_link;
	logic [SW:0]                sfx_link;
	logic [acms_pkg::PAT_W-1:0] ent_pattern;
	logic [OW:0]                ent_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_pos_q <= '0;
			rpt_lo_q   <= '0;
			rpt_hi_q   <= '1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				acms_pkg::CFG_SCAN_START: base_pos_q <= cfg.data;
				acms_pkg::CFG_CORE_START: rpt_lo_q   <= cfg.data;
				acms_pkg::CFG_CORE_END:   rpt_hi_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// The register can take a new result when it is empty or being drained.
	assign out_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (push.push) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.push) begin
			res_pos_q  <= push.end_position;
			res_pat_q  <= push.matched_pattern;
			res_last_q <= push.last_of_byte;
			res_ovf_q  <= push.overflow;
		end
	end

	assign result.valid           = res_valid_q;
	assign result.end_position    = res_pos_q;
	assign result.matched_pattern = res_pat_q;
	assign result.last_of_byte    = res_last_q;
	assign result.overflow        = res_ovf_q;

	acms_seq #(
		.NUM_STATES    (NUM_STATES),
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.NUM_OUTPUTS   (NUM_OUTPUTS),
		.MAX_RESULTS   (MAX_RESULTS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.base_pos    (base_pos_q),
		.rpt_lo      (rpt_lo_q),
		.rpt_hi      (rpt_hi_q),
		.out_free    (out_free),
		.wr          (wr),
		.rd          (rd),
		.trans_state (trans_state),
		.head_link   (head_link),
		.sfx_link    (sfx_link),
		.ent_pattern (ent_pattern),
		.ent_next    (ent_next),
		.push        (push)
	);

	acms_tables #(
		.NUM_STATES    (NUM_STATES),
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.NUM_OUTPUTS   (NUM_OUTPUTS)
	) u_tables (
		.clk         (clk),
		.wr          (wr),
		.rd          (rd),
		.trans_state (trans_state),
		.head_link   (head_link),
		.sfx_link    (sfx_link),
		.ent_pattern (ent_pattern),
		.ent_next    (ent_next)
	);

`ifndef SYNTHESIS
	// A result is only pushed when the output register has room for it.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> out_free)
		else $error("result pushed into a full output register");

	// Results are produced only by a walk, never while new items are taken.
	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push.push |-> !item.ready)
		else $error("result pushed while the item channel is ready");

	// An overflow flag only rides on the final result of a byte.
	a_ovf_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.push && push.overflow |-> push.last_of_byte)
		else $error("overflow flagged on a result that is not the last");
`endif

endmodule
